>>> sv/msrp_pkg.sv
// ----------------------------------------------------------------------------
// Multi-stride region prefetcher package
// Address split, entry record layout, register indexes and small helpers.
// ----------------------------------------------------------------------------
package msrp_pkg;

   localparam int LINE_BITS         = 6;
   localparam int REGION_BITS       = 12;
   localparam int ADDR_BITS         = 48;
   localparam int MAX_DEGREE        = 16;
   localparam int DEF_TABLE_ENTRIES = 16;

   localparam int LINE_W  = ADDR_BITS - LINE_BITS;
   localparam int TAG_W   = ADDR_BITS - REGION_BITS;
   localparam int DEG_CAP = (MAX_DEGREE < 16) ? MAX_DEGREE : 16;

   typedef logic [2:0] csr_idx_type;

   localparam csr_idx_type CSR_THREAD_MATCH = 3'd0;
   localparam csr_idx_type CSR_SINGLE_MODE  = 3'd1;
   localparam csr_idx_type CSR_SINGLE_THR   = 3'd2;
   localparam csr_idx_type CSR_MULTI_THR    = 3'd3;
   localparam csr_idx_type CSR_START_DIST   = 3'd4;
   localparam csr_idx_type CSR_DEGREE       = 3'd5;
   localparam csr_idx_type CSR_DISTANCE     = 3'd6;

   // One table entry as kept in the entry memory
   typedef struct packed {
      logic [LINE_W-1:0] last;
      logic [1:0][31:0]  ps;
      logic [1:0][31:0]  ts;
      logic [1:0][15:0]  pr;
      logic              trained;
      logic              cm;
      logic              two;
      logic              cur;
      logic [15:0]       cnt;
      logic [15:0]       rc;
      logic [15:0]       pc;
      logic              pp;
      logic [LINE_W-1:0] il;
      logic [6:0]        outst;
   } entry_type;

   function automatic logic [15:0] inc16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [LINE_W-1:0] sext_stride(input logic [31:0] s);
      return {{(LINE_W-32){s[31]}}, s};
   endfunction

   // Drop training, keep issue position fields
   function automatic entry_type clear_training(input entry_type e);
      entry_type r;
      r         = e;
      r.trained = 1'b0;
      r.cm      = 1'b0;
      r.two     = 1'b0;
      r.cur     = 1'b0;
      r.ps      = '0;
      r.ts      = '0;
      r.pr      = '0;
      r.cnt     = '0;
      r.rc      = '0;
      r.outst   = '0;
      return r;
   endfunction

endpackage

>>> sv/msrp_ifs.sv
// ----------------------------------------------------------------------------
// Multi-stride region prefetcher channels
// Access request, prefetch response and register write channels.
// ----------------------------------------------------------------------------
interface msrp_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  thread_id;
   logic [47:0] byte_address;
   logic        hit_in_l2;
   logic [4:0]  queue_free;

   modport source (output valid, thread_id, byte_address, hit_in_l2, queue_free,
                   input ready);
   modport sink   (input valid, thread_id, byte_address, hit_in_l2, queue_free,
                   output ready);
endinterface

interface msrp_rsp_if;
   logic        valid;
   logic        ready;
   logic        prefetch_valid;
   logic [41:0] prefetch_line;
   logic        last_result;

   modport source (output valid, prefetch_valid, prefetch_line, last_result,
                   input ready);
   modport sink   (input valid, prefetch_valid, prefetch_line, last_result,
                   output ready);
endinterface

interface msrp_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/multi_stride_region_prefetcher_top.sv
// ----------------------------------------------------------------------------
// Multi-stride region prefetcher
// Region table lookup, stride training and prefetch line emission.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     carries
//  req_chan  in   valid/ready   thread_id, byte_address, hit_in_l2, queue_free
//  rsp_chan  out  valid/ready   prefetch_valid, prefetch_line, last_result
//  csr_chan  in   valid/ready   index, data (always ready)
//
//  One item at a time. A miss that hit in L2 only advances the access
//  counter. A miss with a free entry allocates it; a miss on a full
//  table first runs the LRU age scan over all TABLE_ENTRIES entries.
//  An untrained hit trains the entry, with a multiply when a single
//  stride finishes training and a walk of start_distance strides when a
//  two-stride pattern does. A trained hit emits prefetches, one result
//  per cycle while rsp_chan is not stalled. Reset clears the valid bits
//  and the access counter and sets the registers to their defaults; no
//  clearing pass. A stalled rsp_chan holds emission; the next item is
//  taken while the last result still waits in the output register.
// ----------------------------------------------------------------------------
module multi_stride_region_prefetcher_top
   import msrp_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
   input logic       clock,
   input logic       reset,
   msrp_req_if.sink  req_chan,
   msrp_rsp_if.source rsp_chan,
   msrp_csr_if.sink  csr_chan
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_LOOKUP, S_SCAN, S_FETCH, S_LOAD, S_STEP,
      S_CHECK, S_MUL, S_SKIP, S_EMIT, S_WRITE
   } state_type;

   state_type state_ff, state_in;

   // registers
   logic       cfg_thr_ff, cfg_single_ff;
   logic [7:0] cfg_sthr_ff, cfg_mthr_ff;
   logic [5:0] cfg_sd_ff;
   logic [4:0] cfg_deg_ff;
   logic [6:0] cfg_dist_ff;

   // latched item
   logic [3:0]        tid_ff, tid_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic              l2hit_ff, l2hit_in;
   logic [4:0]        qfree_ff, qfree_in;

   // region table (flops) and entry memory
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TAG_W-1:0]         tag_arr  [TABLE_ENTRIES];
   logic [3:0]               thr_arr  [TABLE_ENTRIES];
   logic [15:0]              stamp_arr[TABLE_ENTRIES];
   entry_type                mem      [TABLE_ENTRIES];
   entry_type                rd_ff;

   logic [15:0]  clock_ff, clock_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          alloc_ff, alloc_in;
   logic [IW-1:0] scan_ff, scan_in, best_idx_ff, best_idx_in;
   logic [15:0]   best_age_ff, best_age_in;
   entry_type     w_ff, w_in;
   logic [5:0]    k_ff, k_in;
   logic          mode_b_ff, mode_b_in;
   logic signed [38:0] prod_ff, prod_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [LINE_W-1:0] rsp_line_ff, rsp_line_in;
   logic              rsp_last_ff, rsp_last_in;

   // table write strobes
   logic tbl_alloc, thr_we, stamp_we, mem_we;

   // lookup
   logic [TABLE_ENTRIES-1:0] hit_vec;
   logic          hit_any, free_any;
   logic [IW-1:0] hit_idx, free_idx;

   always_comb begin
      hit_any  = 1'b0;
      free_any = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         hit_vec[i] = valid_ff[i] && (tag_arr[i] == tag_ff) &&
                      (!cfg_thr_ff || (thr_arr[i] == tid_ff));
         if (hit_vec[i]) begin
            hit_any = 1'b1;
            hit_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   // next-state and datapath
   logic [15:0]       age_cur;
   logic              take;
   logic [31:0]       st;
   logic              c;
   logic [4:0]        deg;
   logic [6:0]        outst_d;
   logic              single_t, multi_t;
   logic              jump, cont, out_free;
   logic [31:0]       step_s;
   logic [LINE_W-1:0] p;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign deg = (cfg_deg_ff > 5'(DEG_CAP)) ? 5'(DEG_CAP) : cfg_deg_ff;

   always_comb begin
      state_in     = state_ff;
      tid_in       = tid_ff;
      line_in      = line_ff;
      tag_in       = tag_ff;
      l2hit_in     = l2hit_ff;
      qfree_in     = qfree_ff;
      clock_in     = clock_ff;
      idx_in       = idx_ff;
      alloc_in     = alloc_ff;
      scan_in      = scan_ff;
      best_idx_in  = best_idx_ff;
      best_age_in  = best_age_ff;
      w_in         = w_ff;
      k_in         = k_ff;
      mode_b_in    = mode_b_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_line_in  = rsp_line_ff;
      rsp_last_in  = rsp_last_ff;
      tbl_alloc    = 1'b0;
      thr_we       = 1'b0;
      stamp_we     = 1'b0;
      mem_we       = 1'b0;
      age_cur      = clock_ff - stamp_arr[scan_ff];
      take         = (scan_ff == '0) || (age_cur > best_age_ff);
      st           = 32'(line_ff - w_ff.last);
      c            = w_ff.cur;
      outst_d      = (w_ff.outst != '0) ? w_ff.outst - 7'd1 : 7'd0;
      single_t     = w_ff.pr[w_ff.cur] >= {8'd0, cfg_sthr_ff};
      multi_t      = w_ff.rc >= {8'd0, cfg_mthr_ff};
      jump         = w_ff.pc == w_ff.pr[w_ff.pp];
      step_s       = !mode_b_ff ? w_ff.ps[0] :
                     (jump ? w_ff.ts[w_ff.pp] : w_ff.ps[w_ff.pp]);
      p            = w_ff.il + sext_stride(step_s);
      cont         = ({1'b0, k_ff} + 7'd1 < {2'd0, deg}) &&
                     ({1'b0, w_ff.outst} + 8'd1 < {1'b0, cfg_dist_ff}) &&
                     ({1'b0, k_ff} + 7'd1 < {2'd0, qfree_ff});

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               tid_in   = req_chan.thread_id;
               line_in  = req_chan.byte_address[ADDR_BITS-1:LINE_BITS];
               tag_in   = req_chan.byte_address[ADDR_BITS-1:REGION_BITS];
               l2hit_in = req_chan.hit_in_l2;
               qfree_in = req_chan.queue_free;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            // hit trains, miss allocates unless the access hit in L2
            if (hit_any) begin
               idx_in   = hit_idx;
               alloc_in = 1'b0;
               state_in = S_FETCH;
            end else if (l2hit_ff) begin
               clock_in = clock_ff + 16'd1;
               state_in = S_IDLE;
            end else if (free_any) begin
               idx_in   = free_idx;
               alloc_in = 1'b1;
               state_in = S_FETCH;
            end else begin
               scan_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // oldest entry wins, ties to the lowest index
            if (take) begin
               best_age_in = age_cur;
               best_idx_in = scan_ff;
            end
            if (scan_ff == LAST_IDX) begin
               idx_in   = take ? scan_ff : best_idx_ff;
               alloc_in = 1'b1;
               state_in = S_FETCH;
            end else begin
               scan_in = scan_ff + IW'(1);
            end
         end
         S_FETCH: state_in = S_LOAD;
         S_LOAD: begin
            stamp_we = 1'b1;
            if (alloc_ff) begin
               tbl_alloc   = 1'b1;
               w_in        = clear_training(rd_ff);
               w_in.last   = line_ff;
               state_in    = S_WRITE;
            end else begin
               w_in     = rd_ff;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            w_in.last = line_ff;
            if (!w_ff.trained) begin
               state_in = S_CHECK;
               if (!w_ff.cm) begin
                  if (w_ff.ps[c] == '0 || (w_ff.ps[c] != st && cfg_single_ff)) begin
                     w_in.ps[c] = st;
                     w_in.pr[c] = 16'd1;
                  end else if (w_ff.ps[c] == st) begin
                     w_in.pr[c] = inc16(w_ff.pr[c]);
                  end else begin
                     w_in.ts[c] = st;
                     w_in.two   = 1'b1;
                     w_in.cur   = ~c;
                     if (c) begin
                        w_in.cm  = 1'b1;
                        w_in.cnt = '0;
                        w_in.rc  = '0;
                     end
                  end
               end else if (st == w_ff.ps[c] && w_ff.cnt < w_ff.pr[c]) begin
                  w_in.rc  = inc16(w_ff.rc);
                  w_in.cnt = inc16(w_ff.cnt);
               end else if (st == w_ff.ts[c] && w_ff.cnt == w_ff.pr[c]) begin
                  w_in.rc  = inc16(w_ff.rc);
                  w_in.cnt = '0;
                  w_in.cur = ~c;
               end else begin
                  // verify failed: take the entry over for this access
                  thr_we    = 1'b1;
                  w_in      = clear_training(w_ff);
                  w_in.last = line_ff;
               end
            end else begin
               w_in.outst = outst_d;
               k_in       = '0;
               state_in   = S_EMIT;
               if (!w_ff.two && st == w_ff.ps[0]) begin
                  mode_b_in = 1'b0;
               end else if ((st == w_ff.ps[c] && w_ff.cnt < w_ff.pr[c]) ||
                            (st == w_ff.ts[c] && w_ff.cnt == w_ff.pr[c])) begin
                  mode_b_in = 1'b1;
                  if (w_ff.cnt == w_ff.pr[c]) begin
                     w_in.cnt = '0;
                     w_in.cur = ~c;
                  end else begin
                     w_in.cnt = inc16(w_ff.cnt);
                  end
               end else begin
                  w_in      = clear_training(w_ff);
                  w_in.last = line_ff;
                  state_in  = S_WRITE;
               end
               if (deg == '0 || outst_d >= cfg_dist_ff || qfree_ff == '0) begin
                  state_in = S_WRITE;
               end
            end
         end
         S_CHECK: begin
            state_in = S_WRITE;
            if (single_t) begin
               w_in.trained = 1'b1;
               w_in.two     = 1'b0;
               w_in.cur     = 1'b0;
               w_in.ps[0]   = w_ff.ps[w_ff.cur];
               prod_in      = $signed(w_ff.ps[w_ff.cur]) * $signed({1'b0, cfg_sd_ff});
               state_in     = S_MUL;
            end
            if (multi_t) begin
               w_in.trained = 1'b1;
               w_in.pc      = w_ff.cnt;
               w_in.pp      = single_t ? 1'b0 : w_ff.cur;
               w_in.il      = line_ff;
               k_in         = '0;
               state_in     = (cfg_sd_ff != '0) ? S_SKIP : S_WRITE;
            end
         end
         S_MUL: begin
            w_in.il  = line_ff + {{(LINE_W-39){prod_ff[38]}}, prod_ff};
            state_in = S_WRITE;
         end
         S_SKIP: begin
            // walk start_distance strides ahead, one per cycle
            if (jump) begin
               w_in.il = w_ff.il + sext_stride(w_ff.ts[w_ff.pp]);
               w_in.pc = '0;
               w_in.pp = ~w_ff.pp;
            end else begin
               w_in.il = w_ff.il + sext_stride(w_ff.ps[w_ff.pp]);
               w_in.pc = inc16(w_ff.pc);
            end
            k_in = k_ff + 6'd1;
            if (k_ff + 6'd1 == cfg_sd_ff) begin
               state_in = S_WRITE;
            end
         end
         S_EMIT: begin
            // one prefetch per cycle while the output register drains
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_line_in  = p;
               rsp_last_in  = !cont;
               w_in.il      = p;
               w_in.outst   = w_ff.outst + 7'd1;
               if (mode_b_ff) begin
                  if (jump) begin
                     w_in.pc = '0;
                     w_in.pp = ~w_ff.pp;
                  end else begin
                     w_in.pc = inc16(w_ff.pc);
                  end
               end
               k_in = k_ff + 6'd1;
               if (!cont) begin
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            mem_we   = 1'b1;
            clock_in = clock_ff + 16'd1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state, table and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         clock_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         cfg_thr_ff    <= 1'b0;
         cfg_single_ff <= 1'b0;
         cfg_sthr_ff   <= 8'd4;
         cfg_mthr_ff   <= 8'd4;
         cfg_sd_ff     <= 6'd4;
         cfg_deg_ff    <= 5'd2;
         cfg_dist_ff   <= 7'd16;
      end else begin
         state_ff     <= state_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tbl_alloc) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               CSR_THREAD_MATCH: cfg_thr_ff    <= csr_chan.data[0];
               CSR_SINGLE_MODE:  cfg_single_ff <= csr_chan.data[0];
               CSR_SINGLE_THR:   cfg_sthr_ff   <= csr_chan.data;
               CSR_MULTI_THR:    cfg_mthr_ff   <= csr_chan.data;
               CSR_START_DIST:   cfg_sd_ff     <= csr_chan.data[5:0];
               CSR_DEGREE:       cfg_deg_ff    <= csr_chan.data[4:0];
               CSR_DISTANCE:     cfg_dist_ff   <= csr_chan.data[6:0];
               default: ;
            endcase
         end
      end
      tid_ff      <= tid_in;
      line_ff     <= line_in;
      tag_ff      <= tag_in;
      l2hit_ff    <= l2hit_in;
      qfree_ff    <= qfree_in;
      idx_ff      <= idx_in;
      alloc_ff    <= alloc_in;
      scan_ff     <= scan_in;
      best_idx_ff <= best_idx_in;
      best_age_ff <= best_age_in;
      w_ff        <= w_in;
      k_ff        <= k_in;
      mode_b_ff   <= mode_b_in;
      prod_ff     <= prod_in;
      rsp_line_ff <= rsp_line_in;
      rsp_last_ff <= rsp_last_in;
      if (tbl_alloc) begin
         tag_arr[idx_ff] <= tag_ff;
      end
      if (tbl_alloc || thr_we) begin
         thr_arr[idx_ff] <= tid_ff;
      end
      if (stamp_we) begin
         stamp_arr[idx_ff] <= clock_ff;
      end
   end

   // entry memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_ff] <= w_ff;
      end
      rd_ff <= mem[idx_ff];
   end

   assign req_chan.ready          = (state_ff == S_IDLE);
   assign csr_chan.ready          = 1'b1;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.prefetch_valid = 1'b1;
   assign rsp_chan.prefetch_line  = rsp_line_ff;
   assign rsp_chan.last_result    = rsp_last_ff;

   // checks
   a_emit_queue: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> (k_ff < {1'b0, qfree_ff}))
      else $error("emission past free queue slots");

   a_emit_outst: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> (w_ff.outst < cfg_dist_ff))
      else $error("outstanding limit exceeded");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_EMIT)
      else $error("result raised outside emission");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("second item taken while busy");

endmodule
